// File: rtl/wdbe_pkg.sv
// shared types and constants for the window debounce edge detector
package wdbe_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned WidthW  = 4;
  localparam int unsigned WinW    = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = PeriodW;

  localparam logic [CfgIdxW-1:0] CfgSamplePeriod = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowWidth  = 1'd1;

  localparam logic [PeriodW-1:0] PeriodReset = 16'd10;
  localparam logic [WidthW-1:0]  WidthReset  = 4'd4;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_TRANS = 2'd1,
    ST_LOW   = 2'd2,
    ST_HIGH  = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    logic    changed;
    logic    rising;
    logic    falling;
    logic    stable_level;
  } result_t;

endpackage

// File: rtl/wdbe_core.sv
// sampling window, classification and stable-level state
module wdbe_core import wdbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               raw_level_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [PeriodW-1:0] period_i,
  input  logic [WidthW-1:0]  width_i,
  output result_t            res_o
);

  logic [TimeW-1:0] last_q, last_d;
  logic [WinW-1:0]  win_q, win_d;
  logic             level_q, level_d;

  logic [TimeW-1:0] elapsed;
  logic             take;
  logic [WinW-1:0]  mask;
  logic [WinW-1:0]  shifted;
  status_e          status;

  // width saturates to 1..8
  always_comb begin
    case (width_i)
      4'd0, 4'd1: mask = 8'h01;
      4'd2:       mask = 8'h03;
      4'd3:       mask = 8'h07;
      4'd4:       mask = 8'h0f;
      4'd5:       mask = 8'h1f;
      4'd6:       mask = 8'h3f;
      4'd7:       mask = 8'h7f;
      default:    mask = 8'hff;
    endcase
  end

  assign elapsed = now_ms_i - last_q;
  assign take    = elapsed >= {{(TimeW-PeriodW){1'b0}}, period_i};
  assign shifted = {win_q[WinW-2:0], raw_level_i} & mask;

  always_comb begin
    last_d  = last_q;
    win_d   = win_q;
    level_d = level_q;
    status  = ST_NONE;
    res_o   = '0;
    if (take) begin
      last_d = now_ms_i;
      win_d  = shifted;
      if (shifted == mask) begin
        status = ST_HIGH;
      end else if (shifted == '0) begin
        status = ST_LOW;
      end else begin
        status = ST_TRANS;
      end
    end
    // only a stable window can move the remembered level
    if ((status == ST_HIGH || status == ST_LOW) && (status[0] != level_q)) begin
      level_d       = status[0];
      res_o.changed = 1'b1;
      res_o.rising  = status[0];
      res_o.falling = ~status[0];
    end
    res_o.status       = status;
    res_o.stable_level = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      win_q   <= '0;
      level_q <= 1'b0;
    end else if (adv_i) begin
      last_q  <= last_d;
      win_q   <= win_d;
      level_q <= level_d;
    end
  end

endmodule

// File: rtl/window_debounce_edge_detector_unit.sv
// Shift-register debouncer with stable-level edge detection. Each word
// carries a raw pin level and a millisecond timestamp; one result word comes
// out per input word. A word passes an input register, is evaluated
// combinationally against the sample timer, window and remembered level, and
// lands in a result register. One word is taken every cycle while the output
// side keeps up; the limit is the single state update per cycle in the window
// logic. Configuration (sample period, window width) uses a plain write port;
// the user must write it only while the block idles; nothing enforces it.
module window_debounce_edge_detector_unit import wdbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                raw_level_i,
  input  logic [TimeW-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          window_status_o,
  output logic                changed_o,
  output logic                rising_o,
  output logic                falling_o,
  output logic                stable_level_o
);

  logic [PeriodW-1:0] period_q;
  logic [WidthW-1:0]  width_q;

  logic               in_valid_q, in_valid_d;
  logic               in_level_q;
  logic [TimeW-1:0]   in_now_q;
  logic               out_valid_q, out_valid_d;
  result_t            res_q;
  result_t            res;

  logic accept;
  logic adv;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      width_q     <= WidthReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSamplePeriod: period_q <= cfg_data_i;
          CfgWindowWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          default: ;
        endcase
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_level_q <= raw_level_i;
      in_now_q   <= now_ms_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  wdbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .raw_level_i (in_level_q),
    .now_ms_i    (in_now_q),
    .period_i    (period_q),
    .width_i     (width_q),
    .res_o       (res)
  );

  assign out_valid_o     = out_valid_q;
  assign window_status_o = res_q.status;
  assign changed_o       = res_q.changed;
  assign rising_o        = res_q.rising;
  assign falling_o       = res_q.falling;
  assign stable_level_o  = res_q.stable_level;

`ifndef SYNTHESIS
  a_change_one_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> (rising_o != falling_o))
    else $error("change without exactly one edge");

  a_rise_is_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rising_o |-> stable_level_o && window_status_o == ST_HIGH)
    else $error("rising edge without stable high window");

  a_no_sample_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (window_status_o == ST_NONE || window_status_o == ST_TRANS)
      |-> !changed_o && !rising_o && !falling_o)
    else $error("edge flagged without stable window");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled while pipeline can move");

  a_level_held_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !res.changed |-> res.stable_level == u_core.level_q)
    else $error("stable level moved without change");
`endif

endmodule

// File: test/tb_top.sv
// self-checking testbench for the window debounce edge detector unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wdbe_pkg::*;

  localparam int NumPhases = 10;
  localparam logic [PeriodW-1:0] PhasePeriod [NumPhases] =
    '{16'd0, 16'd1, 16'd65535, 16'd3, 16'd10, 16'd2, 16'd7, 16'd20, 16'd5, 16'd4};
  localparam logic [WidthW-1:0] PhaseWidth [NumPhases] =
    '{4'd1, 4'd8, 4'd9, 4'd0, 4'd4, 4'd15, 4'd2, 4'd6, 4'd3, 4'd5};

  typedef struct {
    logic             level;
    logic [TimeW-1:0] stamp;
    int unsigned      gap;
  } pin_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                raw_level = 1'b0;
  logic [TimeW-1:0]    now_ms = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          window_status;
  logic                changed;
  logic                rising;
  logic                falling;
  logic                stable_level;

  // mirror of the block's registers and state
  logic [PeriodW-1:0]  period_cfg = PeriodReset;
  logic [WidthW-1:0]   width_cfg = WidthReset;
  logic [TimeW-1:0]    last_stamp = '0;
  logic [WinW-1:0]     window_q = '0;
  logic                held_level = 1'b0;

  pin_word_t   word_queue [$];
  result_t     due_results [$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned settings_seen = 1;
  int unsigned tx_mode = 0;
  int unsigned rx_mode = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_hold = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  logic [TimeW-1:0] clock_ms = '0;
  logic        settled = 1'b0;

  window_debounce_edge_detector_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .raw_level_i     (raw_level),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .window_status_o (window_status),
    .changed_o       (changed),
    .rising_o        (rising),
    .falling_o       (falling),
    .stable_level_o  (stable_level)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic result_t predict_debounce(logic level, logic [TimeW-1:0] stamp);
    result_t          res;
    logic [TimeW-1:0] elapsed;
    int unsigned      keep;
    logic [WinW-1:0]  mask;
    logic             stable;
    res.status  = ST_NONE;
    res.changed = 1'b0;
    res.rising  = 1'b0;
    res.falling = 1'b0;
    elapsed = stamp - last_stamp;
    if (elapsed >= TimeW'(period_cfg)) begin
      // width saturates to 1..8
      keep = (width_cfg == 0) ? 1 : (width_cfg > WinW) ? WinW : width_cfg;
      mask = WinW'((1 << keep) - 1);
      last_stamp = stamp;
      window_q = ((window_q << 1) | WinW'(level)) & mask;
      if (window_q == mask) res.status = ST_HIGH;
      else if (window_q == '0) res.status = ST_LOW;
      else res.status = ST_TRANS;
      if (res.status == ST_HIGH || res.status == ST_LOW) begin
        stable = (res.status == ST_HIGH);
        if (stable != held_level) begin
          held_level  = stable;
          res.changed = 1'b1;
          res.rising  = stable;
          res.falling = ~stable;
        end
      end
    end
    res.stable_level = held_level;
    return res;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb_top: %s", msg);
  endtask

  // result checking and prediction of accepted words
  always @(posedge clk) begin : check_p
    result_t want;
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("result word with nothing outstanding: st=%0d chg=%b r=%b f=%b lvl=%b",
                             window_status, changed, rising, falling, stable_level));
      end else begin
        want = due_results.pop_front();
        words_checked++;
        if (window_status !== want.status || changed !== want.changed ||
            rising !== want.rising || falling !== want.falling ||
            stable_level !== want.stable_level) begin
          flag_error($sformatf(
            "word %0d: exp st=%0d chg=%b r=%b f=%b lvl=%b, got st=%0d chg=%b r=%b f=%b lvl=%b",
            words_checked, want.status, want.changed, want.rising, want.falling,
            want.stable_level, window_status, changed, rising, falling, stable_level));
        end
      end
    end
    if (in_valid && !in_stall) due_results.push_back(predict_debounce(raw_level, now_ms));
  end

  // sender: a stalled word is held, otherwise the next one goes out after its gap
  always @(negedge clk) begin : drive_p
    pin_word_t cur;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (word_queue.size() != 0 && tx_wait >= word_queue[0].gap) begin
        cur = word_queue.pop_front();
        in_valid  <= 1'b1;
        raw_level <= cur.level;
        now_ms    <= cur.stamp;
        tx_wait = 0;
      end else begin
        in_valid <= 1'b0;
        if (word_queue.size() != 0) tx_wait++;
      end
    end
  end

  // receiver: back-pressure drawn afresh after each accepted result
  always @(negedge clk) begin
    if (out_taken) begin
      case (rx_mode)
        0: rx_hold = 0;
        1: rx_hold = $urandom_range(0, 17);
        default: rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      endcase
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_word(logic level, logic [TimeW-1:0] stamp);
    pin_word_t w;
    w.level = level;
    w.stamp = stamp;
    case (tx_mode)
      0: w.gap = 0;
      1: w.gap = $urandom_range(0, 17);
      default: w.gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
    endcase
    word_queue.push_back(w);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgSamplePeriod) period_cfg = data;
    else width_cfg = data[WidthW-1:0];
  endtask

  task automatic wait_drained();
    while (word_queue.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // bouncing pin with mostly on-period timestamps, plus noise and time jumps
  task automatic run_random(int unsigned count);
    int unsigned      pick;
    logic [TimeW-1:0] step;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 11) == 0) settled = ~settled;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        push_word(1'($urandom), $urandom);
      end else begin
        if (pick < 60) step = period_cfg + $urandom_range(0, 3);
        else if (pick < 78) step = (period_cfg == 0) ? 0 : $urandom_range(0, period_cfg - 1);
        else if (pick < 86) step = 0;
        else if (pick < 94) step = $urandom;
        else step = -TimeW'($urandom_range(1, 1000));
        clock_ms += step;
        push_word(($urandom_range(0, 4) == 0) ? ~settled : settled, clock_ms);
      end
    end
  endtask

  initial begin : stimulus_p
    logic [CfgDataW-1:0] width_word;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: period 10, width 4
    tx_mode = 1;
    rx_mode = 1;
    push_word(1'b1, 32'd0);
    push_word(1'b1, 32'd9);
    push_word(1'b1, 32'd10);
    push_word(1'b1, 32'd20);
    push_word(1'b1, 32'd30);
    push_word(1'b1, 32'd40);
    push_word(1'b0, 32'd45);
    push_word(1'b0, 32'd50);
    push_word(1'b0, 32'd5);            // time goes backwards
    push_word(1'b0, 32'hFFFF_FFFF);
    push_word(1'b0, 32'd9);            // difference wraps through zero
    wait_drained();
    // zero period, width of zero behaves as one
    write_reg(CfgSamplePeriod, 16'd0);
    write_reg(CfgWindowWidth, 16'hFFF0);
    push_word(1'b1, 32'd9);
    push_word(1'b0, 32'd9);
    push_word(1'b0, 32'd9);
    push_word(1'b1, 32'h8000_0000);
    wait_drained();
    // width above eight saturates
    write_reg(CfgWindowWidth, 16'h000F);
    push_word(1'b1, 32'h8000_0000);
    push_word(1'b0, 32'h8000_0000);
    push_word(1'b1, 32'h8000_0000);
    wait_drained();
    write_reg(CfgSamplePeriod, 16'hFFFF);
    write_reg(CfgWindowWidth, 16'h0008);
    push_word(1'b1, 32'h8000_FFFE);
    push_word(1'b1, 32'h8000_FFFF);
    push_word(1'b0, 32'h7FFF_FFFF);
    wait_drained();
    settings_seen += 3;

    clock_ms = 32'h7FFF_FFFF;
    for (int p = 0; p < NumPhases; p++) begin
      tx_mode = p % 3;
      rx_mode = (p / 3) % 3;
      width_word = CfgDataW'($urandom);
      width_word[WidthW-1:0] = PhaseWidth[p];
      write_reg(CfgSamplePeriod, PhasePeriod[p]);
      write_reg(CfgWindowWidth, width_word);
      settings_seen++;
      if (p == 2) clock_ms = 32'hFFFF_0000;   // run across the timestamp wrap
      if (p == 4) begin
        run_random(80);
        wait_drained();                       // sender holds off until all results are in
        run_random(80);
      end else begin
        run_random(160);
      end
      wait_drained();
    end

    $display("tb_top: %0d result words checked over %0d register settings, %0d mismatches",
             words_checked, settings_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top: timeout with %0d results outstanding", due_results.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/wdbe_pkg.sv
rtl/wdbe_core.sv
rtl/window_debounce_edge_detector_unit.sv
test/tb_top.sv
